### rtl/gcf_pkg.sv
// gcf_pkg: shared types, constants and calendar tables for the calendar fields core
// depends on nothing; imported by every rtl module of the block

package gcf_pkg;

  // pipeline depth, one register stage each
  localparam int unsigned NumStages = 7;

  // field widths
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned OrdW   = 9;
  localparam int unsigned WeekW  = 6;

  // month codes
  localparam logic [MonthW-1:0] MonJan = 4'd1;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;
  localparam logic [MonthW-1:0] MonMar = 4'd3;
  localparam logic [MonthW-1:0] MonDec = 4'd12;

  // iso week numbers with special meaning
  localparam logic [WeekW-1:0] WeekFirst = 6'd1;
  localparam logic [WeekW-1:0] WeekLong  = 6'd53;
  localparam logic [WeekW-1:0] WeekShort = 6'd52;

  // weekday codes, monday based
  localparam logic [2:0] DowFri = 3'd4;
  localparam logic [2:0] DowSat = 3'd5;
  localparam logic [2:0] DowSun = 3'd6;

  // reciprocal constants: floor(n / d) = (n * Recip) >> Shift over the value range used
  localparam logic [29:0] Recip25   = 30'd20972;  // d = 25, shift 19
  localparam logic [29:0] Recip100  = 30'd20972;  // d = 100, shift 21
  localparam logic [29:0] Recip400  = 30'd20972;  // d = 400, shift 23
  localparam logic [30:0] Recip7Y   = 31'd37450;  // d = 7 on year sums, shift 18
  localparam logic [18:0] Recip7W   = 19'd586;    // d = 7 on day counts, shift 12
  localparam logic [11:0] Recip7S   = 12'd37;     // d = 7 on values below 64, shift 8

  // year offsets: YearBias keeps the weekday formula non-negative, YearPrevBias gives the previous year plus 400
  localparam logic [YearW:0] YearBias     = 15'd400;
  localparam logic [YearW:0] YearPrevBias = 15'd399;

  // stage three payload, handed from the year unit to the week unit
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic              leap;
    logic              leap_prev;
    logic [DayW-1:0]   dim;
    logic [OrdW-1:0]   doy;
    logic [YearW:0]    ysum;
    logic [11:0]       q7;
  } gcf_yr_t;

  // final result word
  typedef struct packed {
    logic              leap;
    logic [2:0]        weekday;
    logic [OrdW-1:0]   ordinal_day;
    logic [DayW-1:0]   month_length;
    logic [YearW-1:0]  week_year;
    logic [WeekW-1:0]  week_number;
    logic [2:0]        week_day;
    logic [1:0]        first_workday;
    logic [DayW-1:0]   last_workday;
  } gcf_res_t;

  // pipeline control
  typedef struct packed {
    logic [NumStages-1:0] en;
    logic                 in_stall;
    logic                 out_valid;
  } gcf_ctl_t;

  // monday based month offset for the weekday formula
  function automatic logic [2:0] sak_of(input logic [MonthW-1:0] m);
    logic [2:0] r;
    case (m)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  // days before the first of the month in a common year
  function automatic logic [OrdW-1:0] cum_of(input logic [MonthW-1:0] m);
    logic [OrdW-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

  // month length in a common year
  function automatic logic [DayW-1:0] mlen_of(input logic [MonthW-1:0] m);
    logic [DayW-1:0] r;
    case (m)
      4'd2:                       r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
      default:                    r = 5'd31;
    endcase
    return r;
  endfunction

  // n mod 7 for n below 64
  function automatic logic [2:0] mod7_small(input logic [5:0] n);
    logic [11:0] prod;
    logic [5:0]  q7x;
    logic [5:0]  r;
    prod = {6'd0, n} * Recip7S;
    q7x  = {2'd0, prod[11:8]} * 6'd7;
    r    = n - q7x;
    return r[2:0];
  endfunction

endpackage

### rtl/gcf_pipe_ctl.sv
// gcf_pipe_ctl: valid bits and per-stage load enables of the calendar pipeline
// depends on gcf_pkg

module gcf_pipe_ctl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_stall_i,
  output gcf_pkg::gcf_ctl_t ctl_o
);
  import gcf_pkg::*;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  // a stage loads when it is empty or its successor moves on
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign ctl_o.en        = en;
  assign ctl_o.in_stall  = !en[0];
  assign ctl_o.out_valid = v_q[NumStages-1];

endmodule

### rtl/gcf_year_unit.sv
// gcf_year_unit: stages one to three, leap flags, month length, ordinal day, year sum
// depends on gcf_pkg

module gcf_year_unit (
  input  logic                        clk_i,
  input  logic [2:0]                  en_i,
  input  logic [gcf_pkg::YearW-1:0]   year_i,
  input  logic [gcf_pkg::MonthW-1:0]  month_i,
  input  logic [gcf_pkg::DayW-1:0]    day_i,
  output gcf_pkg::gcf_yr_t            yr_o
);
  import gcf_pkg::*;

  // stage one registers
  logic [YearW-1:0]  y1_q;
  logic [MonthW-1:0] m1_q, m1_d;
  logic [DayW-1:0]   d1_q;
  logic [9:0]        q25y_q, q25y_d;
  logic [9:0]        q25p_q, q25p_d;
  logic [YearW:0]    yy1_q, yy1_d;
  logic [7:0]        q100_q, q100_d;
  logic [5:0]        q400_q, q400_d;

  // stage two registers
  logic [YearW-1:0]  y2_q;
  logic [MonthW-1:0] m2_q;
  logic [DayW-1:0]   d2_q, d2_d;
  logic              leap2_q, leap2_d;
  logic              leapp2_q, leapp2_d;
  logic [DayW-1:0]   dim2_q, dim2_d;
  logic [YearW:0]    ysum2_q, ysum2_d;

  // stage three register
  gcf_yr_t           yr3_q, yr3_d;

  // stage one: clamp month, year offsets, quotients by 25, 100 and 400
  always_comb begin
    logic [YearW:0] yp;
    logic [29:0]    p25y, p25p, p100, p400;
    if (month_i < MonJan) begin
      m1_d = MonJan;
    end else if (month_i > MonDec) begin
      m1_d = MonDec;
    end else begin
      m1_d = month_i;
    end
    yp    = {1'b0, year_i} + YearPrevBias;
    yy1_d = {1'b0, year_i} + YearBias - {{YearW{1'b0}}, (m1_d < MonMar)};
    p25y  = 30'(year_i) * Recip25;
    p25p  = 30'(yp) * Recip25;
    p100  = 30'(yy1_d) * Recip100;
    p400  = 30'(yy1_d) * Recip400;
    q25y_d = p25y[28:19];
    q25p_d = p25p[28:19];
    q100_d = p100[28:21];
    q400_d = p400[28:23];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      y1_q   <= year_i;
      m1_q   <= m1_d;
      d1_q   <= day_i;
      q25y_q <= q25y_d;
      q25p_q <= q25p_d;
      yy1_q  <= yy1_d;
      q100_q <= q100_d;
      q400_q <= q400_d;
    end
  end

  // stage two: leap flags, month length, day clamp, weekday year sum
  always_comb begin
    logic [YearW:0] yp;
    logic           div25y, div25p;
    yp       = {1'b0, y1_q} + YearPrevBias;
    div25y   = ((15'(q25y_q) * 15'd25) == {1'b0, y1_q});
    div25p   = ((15'(q25p_q) * 15'd25) == yp);
    leap2_d  = (y1_q[1:0] == 2'd0) && (!div25y || (y1_q[3:0] == 4'd0));
    leapp2_d = (yp[1:0] == 2'd0) && (!div25p || (yp[3:0] == 4'd0));
    dim2_d   = mlen_of(m1_q) + {4'd0, (leap2_d && (m1_q == MonFeb))};
    if (d1_q < 5'd1) begin
      d2_d = 5'd1;
    end else if (d1_q > dim2_d) begin
      d2_d = dim2_d;
    end else begin
      d2_d = d1_q;
    end
    ysum2_d = yy1_q + {2'd0, yy1_q[YearW:2]} - {7'd0, q100_q} + {9'd0, q400_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      y2_q     <= y1_q;
      m2_q     <= m1_q;
      d2_q     <= d2_d;
      leap2_q  <= leap2_d;
      leapp2_q <= leapp2_d;
      dim2_q   <= dim2_d;
      ysum2_q  <= ysum2_d;
    end
  end

  // stage three: quotient of the year sum by 7, ordinal day
  always_comb begin
    logic [30:0] p7;
    p7              = 31'(ysum2_q) * Recip7Y;
    yr3_d.year      = y2_q;
    yr3_d.month     = m2_q;
    yr3_d.day       = d2_q;
    yr3_d.leap      = leap2_q;
    yr3_d.leap_prev = leapp2_q;
    yr3_d.dim       = dim2_q;
    yr3_d.doy       = cum_of(m2_q) + {4'd0, d2_q}
                      + {8'd0, (leap2_q && (m2_q > MonFeb))};
    yr3_d.ysum      = ysum2_q;
    yr3_d.q7        = p7[29:18];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      yr3_q <= yr3_d;
    end
  end

  assign yr_o = yr3_q;

endmodule

### rtl/gcf_week_unit.sv
// gcf_week_unit: stages four to seven, weekdays, iso week date, workday bounds
// depends on gcf_pkg

module gcf_week_unit (
  input  logic              clk_i,
  input  logic [3:0]        en_i,
  input  gcf_pkg::gcf_yr_t  yr_i,
  output gcf_pkg::gcf_res_t res_o
);
  import gcf_pkg::*;

  // common payload carried through stages four to six
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic              leap;
    logic              leap_prev;
    logic [DayW-1:0]   dim;
    logic [OrdW-1:0]   doy;
  } carry_t;

  carry_t          c4_q, c5_q, c6_q;
  logic [5:0]      sdow4_q, sdow4_d;
  logic [5:0]      swd14_q, swd14_d;
  logic [2:0]      dow5_q, wd15_q;
  logic [2:0]      dow6_q;
  logic [WeekW-1:0] wq6_q, wq6_d;
  logic            neg6_q, m1_6_q, m2_6_q;
  logic            near6_q, near6_d;
  logic [DayW-1:0] lastw6_q, lastw6_d;
  logic [1:0]      firstw6_q, firstw6_d;
  gcf_res_t        res7_q, res7_d;
  logic [9:0]      raw6;
  carry_t          c_in;

  assign c_in.year      = yr_i.year;
  assign c_in.month     = yr_i.month;
  assign c_in.day       = yr_i.day;
  assign c_in.leap      = yr_i.leap;
  assign c_in.leap_prev = yr_i.leap_prev;
  assign c_in.dim       = yr_i.dim;
  assign c_in.doy       = yr_i.doy;

  // stage four: year sum mod 7, weekday sums for the date and for the first
  always_comb begin
    logic [YearW:0] rem;
    logic [2:0]     sak;
    rem     = yr_i.ysum - 15'(yr_i.q7 * 12'd7);
    sak     = sak_of(yr_i.month);
    sdow4_d = {3'd0, rem[2:0]} + {3'd0, sak} + {1'b0, yr_i.day} + 6'd6;
    swd14_d = {3'd0, rem[2:0]} + {3'd0, sak};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      c4_q    <= c_in;
      sdow4_q <= sdow4_d;
      swd14_q <= swd14_d;
    end
  end

  // stage five: reduce both sums to a monday based weekday
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      c5_q   <= c4_q;
      dow5_q <= mod7_small(sdow4_q);
      wd15_q <= mod7_small(swd14_q);
    end
  end

  // stage six: week quotient, end-of-year test, workday bounds
  assign raw6 = {1'b0, c5_q.doy} + 10'd2 - {7'd0, dow5_q};

  always_comb begin
    logic [18:0] pw;
    logic [5:0]  tail;
    logic [2:0]  lastdow;
    pw        = 19'(raw6[8:0]) * Recip7W;
    wq6_d     = pw[17:12];
    tail      = 6'd31 - {1'b0, c5_q.day} + {3'd0, dow5_q};
    near6_d   = (tail < 6'd3);
    lastdow   = mod7_small({3'd0, wd15_q} + {1'b0, c5_q.dim} - 6'd1);
    if (lastdow > DowFri) begin
      lastw6_d = c5_q.dim - {2'd0, (lastdow - DowFri)};
    end else begin
      lastw6_d = c5_q.dim;
    end
    if (wd15_q == DowSat) begin
      firstw6_d = 2'd3;
    end else if (wd15_q == DowSun) begin
      firstw6_d = 2'd2;
    end else begin
      firstw6_d = 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      c6_q      <= c5_q;
      dow6_q    <= dow5_q;
      wq6_q     <= wq6_d;
      neg6_q    <= raw6[9];
      m1_6_q    <= (raw6 == 10'h3FF);
      m2_6_q    <= (raw6 == 10'h3FE);
      near6_q   <= near6_d;
      lastw6_q  <= lastw6_d;
      firstw6_q <= firstw6_d;
    end
  end

  // stage seven: iso week number and week-numbering year
  always_comb begin
    logic [WeekW-1:0] wk;
    if (!neg6_q) begin
      wk = wq6_q + 6'd1;
      if ((wk == WeekLong) && near6_q) begin
        wk = WeekFirst;
      end
    end else if (m1_6_q || (m2_6_q && c6_q.leap_prev)) begin
      wk = WeekLong;
    end else begin
      wk = WeekShort;
    end
    res7_d.leap          = c6_q.leap;
    res7_d.weekday       = dow6_q;
    res7_d.ordinal_day   = c6_q.doy;
    res7_d.month_length  = c6_q.dim;
    res7_d.week_number   = wk;
    res7_d.week_day      = dow6_q + 3'd1;
    res7_d.first_workday = firstw6_q;
    res7_d.last_workday  = lastw6_q;
    if ((wk == WeekFirst) && (c6_q.month == MonDec)) begin
      res7_d.week_year = c6_q.year + 14'd1;
    end else if ((wk >= WeekShort) && (c6_q.month == MonJan)) begin
      res7_d.week_year = c6_q.year - 14'd1;
    end else begin
      res7_d.week_year = c6_q.year;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      res7_q <= res7_d;
    end
  end

  assign res_o = res7_q;

endmodule

### rtl/gregorian_calendar_fields_core.sv
// gregorian_calendar_fields_core: top level of the gregorian date to calendar fields block
// depends on gcf_pkg, gcf_pipe_ctl, gcf_year_unit, gcf_week_unit

// Takes one Gregorian date word (year, month, day) per clock, unless in_stall_o is high,
// and returns its leap flag, weekday, ordinal day, month length, ISO week date and
// first/last workday of the month. The datapath is a seven-stage register pipeline; a new
// word can be accepted every cycle unless stalled. Out-of-range months clamp to
// January or December and out-of-range days clamp into the month. When the output is
// stalled, stages fill their empty slots first and in_stall_o rises only once every stage
// holds a word; no word is lost or repeated.

module gregorian_calendar_fields_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [gcf_pkg::YearW-1:0]   in_year_i,
  input  logic [gcf_pkg::MonthW-1:0]  in_month_i,
  input  logic [gcf_pkg::DayW-1:0]    in_day_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        out_leap_o,
  output logic [2:0]                  out_weekday_o,
  output logic [gcf_pkg::OrdW-1:0]    out_ordinal_day_o,
  output logic [gcf_pkg::DayW-1:0]    out_month_length_o,
  output logic [gcf_pkg::YearW-1:0]   out_week_year_o,
  output logic [gcf_pkg::WeekW-1:0]   out_week_number_o,
  output logic [2:0]                  out_week_day_o,
  output logic [1:0]                  out_first_workday_o,
  output logic [gcf_pkg::DayW-1:0]    out_last_workday_o
);
  import gcf_pkg::*;

  gcf_ctl_t ctl;
  gcf_yr_t  yr;
  gcf_res_t res;

  // valid bits and stage enables
  gcf_pipe_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  // stages one to three
  gcf_year_unit u_year (
    .clk_i   (clk_i),
    .en_i    (ctl.en[2:0]),
    .year_i  (in_year_i),
    .month_i (in_month_i),
    .day_i   (in_day_i),
    .yr_o    (yr)
  );

  // stages four to seven
  gcf_week_unit u_week (
    .clk_i (clk_i),
    .en_i  (ctl.en[6:3]),
    .yr_i  (yr),
    .res_o (res)
  );

  assign in_stall_o          = ctl.in_stall;
  assign out_valid_o         = ctl.out_valid;
  assign out_leap_o          = res.leap;
  assign out_weekday_o       = res.weekday;
  assign out_ordinal_day_o   = res.ordinal_day;
  assign out_month_length_o  = res.month_length;
  assign out_week_year_o     = res.week_year;
  assign out_week_number_o   = res.week_number;
  assign out_week_day_o      = res.week_day;
  assign out_first_workday_o = res.first_workday;
  assign out_last_workday_o  = res.last_workday;

endmodule

### rtl/gcf_checker.sv
// gcf_checker: port-level checks on the calendar fields core, bound to the top level
// depends on gcf_pkg and gregorian_calendar_fields_core

module gcf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [gcf_pkg::YearW-1:0]   in_year_i,
  input logic [gcf_pkg::MonthW-1:0]  in_month_i,
  input logic [gcf_pkg::DayW-1:0]    in_day_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        out_leap_o,
  input logic [2:0]                  out_weekday_o,
  input logic [gcf_pkg::OrdW-1:0]    out_ordinal_day_o,
  input logic [gcf_pkg::DayW-1:0]    out_month_length_o,
  input logic [gcf_pkg::YearW-1:0]   out_week_year_o,
  input logic [gcf_pkg::WeekW-1:0]   out_week_number_o,
  input logic [2:0]                  out_week_day_o,
  input logic [1:0]                  out_first_workday_o,
  input logic [gcf_pkg::DayW-1:0]    out_last_workday_o
);
  import gcf_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped under stall");

  // a stalled result word keeps its ordinal day, week year, week number and weekday
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_ordinal_day_o) && $stable(out_week_year_o)
      && $stable(out_week_number_o) && $stable(out_weekday_o))
    else $error("result word changed under stall");

  // iso weekday is the monday based weekday plus one
  a_week_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_week_day_o == (out_weekday_o + 3'd1)))
    else $error("iso weekday disagrees with weekday");

  // last workday lies within the final three days of the month
  a_last_workday: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_last_workday_o <= out_month_length_o)
      && (({1'b0, out_last_workday_o} + 6'd2) >= {1'b0, out_month_length_o}))
    else $error("last workday out of range");

endmodule

bind gregorian_calendar_fields_core gcf_checker u_gcf_checker (.*);
